@@ hw/rtl/fqse_pkg.sv @@
// ---------------------------------------------------------------------------
// fqse_pkg
// Shared types and constants for the searchable FIFO queue.
// ---------------------------------------------------------------------------
`default_nettype none

package fqse_pkg;

    // Queue depth; must be a power of two so pointers wrap naturally.
    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CHANGE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

endpackage

`default_nettype wire

@@ hw/rtl/fqse_store.sv @@
// ---------------------------------------------------------------------------
// fqse_store
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fqse_store (
    input  wire logic                         i_clk,
    input  wire fqse_pkg::t_mem_req           i_req,
    output logic [fqse_pkg::VALUE_W-1:0]      o_rd_data
);

    logic [fqse_pkg::VALUE_W-1:0] r_mem [fqse_pkg::DEPTH];
    logic [fqse_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/fqse_ctrl.sv @@
// ---------------------------------------------------------------------------
// fqse_ctrl
// Command sequencer: pointer/count update, serial search with one shared
// comparator, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fqse_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [fqse_pkg::CMD_W-1:0]        i_command,
    input  wire logic [fqse_pkg::VALUE_W-1:0]      i_value,
    input  wire logic [fqse_pkg::POS_W-1:0]        i_position,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [fqse_pkg::STAT_W-1:0]            o_status,
    output logic                                   o_found,
    output logic [fqse_pkg::CNT_W-1:0]             o_count,
    output fqse_pkg::t_mem_req                     o_mem_req,
    input  wire logic [fqse_pkg::VALUE_W-1:0]      i_rd_data
);

    fqse_pkg::t_state  r_state, n_state;
    logic [fqse_pkg::IDX_W-1:0]   r_head, r_tail;
    logic [fqse_pkg::CNT_W-1:0]   r_count;
    logic [fqse_pkg::CNT_W-1:0]   r_issue;
    logic                         r_pend;
    logic                         r_found;
    fqse_pkg::t_status            r_status;
    logic [fqse_pkg::VALUE_W-1:0] r_value;

    logic                         r_out_valid;
    logic [fqse_pkg::STAT_W-1:0]  r_out_status;
    logic                         r_out_found;
    logic [fqse_pkg::CNT_W-1:0]   r_out_count;

    fqse_pkg::t_cmd               cmd;
    logic                         in_acc;
    logic                         full;
    logic                         empty;
    logic                         pos_ok;
    logic [fqse_pkg::IDX_W-1:0]   pos_idx;
    logic                         scan_done;
    logic                         hit;
    logic                         load_out;

    assign cmd     = fqse_pkg::t_cmd'(i_command);
    assign full    = (r_count == fqse_pkg::CNT_W'(fqse_pkg::DEPTH));
    assign empty   = (r_count == '0);
    assign pos_ok  = (i_position != '0) &&
                     ({{(fqse_pkg::CNT_W){1'b0}}, i_position} <=
                      {{(fqse_pkg::POS_W){1'b0}}, r_count});
    assign pos_idx = r_head + fqse_pkg::IDX_W'(i_position - fqse_pkg::POS_W'(1));
    assign scan_done = (r_issue == r_count) && !r_pend;
    // shared comparator: one stored entry against the search key per cycle
    assign hit      = r_pend && (i_rd_data == r_value);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fqse_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (cmd == fqse_pkg::CMD_SEARCH && !empty) ?
                              fqse_pkg::S_SCAN : fqse_pkg::S_DONE;
                end
            end
            fqse_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = fqse_pkg::S_DONE;
                end
            end
            fqse_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = fqse_pkg::S_IDLE;
                end
            end
            default: n_state = fqse_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        in_acc          = 1'b0;
        load_out        = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_tail;
        o_mem_req.wdata = i_value;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = r_head + r_issue[fqse_pkg::IDX_W-1:0];
        unique case (r_state)
            fqse_pkg::S_IDLE: begin
                in_acc = i_in_valid;
                if (cmd == fqse_pkg::CMD_CHANGE) begin
                    o_mem_req.waddr = pos_idx;
                end
                o_mem_req.we = i_in_valid &&
                               ((cmd == fqse_pkg::CMD_INSERT && !full) ||
                                (cmd == fqse_pkg::CMD_CHANGE && pos_ok));
            end
            fqse_pkg::S_SCAN: begin
                o_mem_req.re = (r_issue != r_count);
            end
            fqse_pkg::S_DONE: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == fqse_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqse_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= o_mem_req.re;
            if (in_acc) begin
                r_issue <= '0;
                unique case (cmd)
                    fqse_pkg::CMD_INSERT: begin
                        if (!full) begin
                            r_tail  <= r_tail + fqse_pkg::IDX_W'(1);
                            r_count <= r_count + fqse_pkg::CNT_W'(1);
                        end
                    end
                    fqse_pkg::CMD_DELETE: begin
                        if (!empty) begin
                            r_head  <= r_head + fqse_pkg::IDX_W'(1);
                            r_count <= r_count - fqse_pkg::CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end else if (o_mem_req.re) begin
                r_issue <= r_issue + fqse_pkg::CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: command context and result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value <= i_value;
            r_found <= 1'b0;
            unique case (cmd)
                fqse_pkg::CMD_INSERT: r_status <= full  ? fqse_pkg::ST_FULL  : fqse_pkg::ST_OK;
                fqse_pkg::CMD_DELETE: r_status <= empty ? fqse_pkg::ST_EMPTY : fqse_pkg::ST_OK;
                fqse_pkg::CMD_CHANGE: r_status <= pos_ok ? fqse_pkg::ST_OK   : fqse_pkg::ST_RANGE;
                default:              r_status <= fqse_pkg::ST_OK;
            endcase
        end else if (hit) begin
            r_found <= 1'b1;
        end
        if (load_out) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_count     = r_out_count;

endmodule

`default_nettype wire

@@ hw/rtl/fifo_queue_with_search_and_edit.sv @@
// ---------------------------------------------------------------------------
// fifo_queue_with_search_and_edit
// Bounded FIFO of signed values with insert, delete, search and positional
// overwrite; one result beat per command.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------
//  in      | i_in_valid / o_in_ready   | i_command, i_value, i_position
//  out     | o_out_valid / i_out_ready | o_status, o_found, o_count
//
//  Insert, delete and change go from the accept straight to the result step.
//  Search walks the queue through the single store read port and one
//  comparator, reading each stored entry in turn; on an empty queue no
//  scan runs and the result step follows the accept directly.
//  Reset is synchronous, active low; the queue is empty after reset.
//  A result not yet taken on i_out_ready holds the next command in its
//  final step, with o_in_ready low.
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search_and_edit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [fqse_pkg::CMD_W-1:0]           i_command,
    input  wire logic signed [fqse_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [fqse_pkg::POS_W-1:0]           i_position,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [fqse_pkg::STAT_W-1:0]               o_status,
    output logic                                      o_found,
    output logic [fqse_pkg::CNT_W-1:0]                o_count
);

    fqse_pkg::t_mem_req            mem_req;
    logic [fqse_pkg::VALUE_W-1:0]  rd_data;

    fqse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_value     (fqse_pkg::VALUE_W'(i_value)),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    fqse_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a beat without going busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fqse_pkg::ST_FULL) |->
        (o_count == fqse_pkg::CNT_W'(fqse_pkg::DEPTH)))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fqse_pkg::ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with entries present");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
        (o_status == fqse_pkg::ST_OK && o_count != '0))
        else $error("found flag on a bad status or empty queue");

endmodule

`default_nettype wire
